/* design/refcounted_slot_cache_lru_evict_top_defines.svh */
// Assertion macros shared by the slot cache RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef REFCOUNTED_SLOT_CACHE_LRU_EVICT_TOP_DEFINES_SVH
`define REFCOUNTED_SLOT_CACHE_LRU_EVICT_TOP_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define RSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* design/rsc_pkg.sv */
// Package for the slot cache: item types, operation, mode and status codes.
// Depends on nothing.
package rsc_pkg;
    localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_FLUSH   = 2'd2;

    localparam logic [1:0] MODE_UNUSED = 2'd0;
    localparam logic [1:0] MODE_ACTIVE = 2'd1;
    localparam logic [1:0] MODE_WARM   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_LOADFAIL = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key;
        logic [3:0]  slot_index;
        logic        load_ok;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] handle_slot;
        logic       hit;
    } t_out_item;

    // Command broadcast to every cell, one per cycle.
    typedef struct packed {
        logic        flush;
        logic        bump;
        logic        warm_hit;
        logic        load;
        logic        clear;
        logic        release_dec;
        logic        go_warm;
        logic [31:0] stamp;
    } t_cell_cmd;
endpackage

/* design/rsc_cell.sv */
// One slot of the cache chain: holds mode, key, count and idle stamp.
// Depends on rsc_pkg. Driven by the command logic and read by the scan logic of the top level.
module rsc_cell #(
    parameter int KEY_BITS = 64,
    parameter int REF_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sel,
    input  rsc_pkg::t_cell_cmd  i_cmd,
    input  logic [KEY_BITS-1:0] i_key,
    output logic [1:0]          o_mode,
    output logic [REF_BITS-1:0] o_refs,
    output logic [31:0]         o_seq,
    output logic                o_match
);
    logic [1:0]          r_mode;
    logic [KEY_BITS-1:0] r_key;
    logic [REF_BITS-1:0] r_refs;
    logic [31:0]         r_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.flush) begin
            r_mode <= rsc_pkg::MODE_UNUSED;
            r_refs <= '0;
            r_seq  <= '0;
        end else if (i_sel) begin
            if (i_cmd.warm_hit || i_cmd.load) begin
                r_mode <= rsc_pkg::MODE_ACTIVE;
                r_refs <= REF_BITS'(1);
                r_seq  <= '0;
                if (i_cmd.load) begin
                    r_key <= i_key;
                end
            end else if (i_cmd.bump) begin
                if (r_refs != {REF_BITS{1'b1}}) begin
                    r_refs <= r_refs + REF_BITS'(1);
                end
            end else if (i_cmd.clear) begin
                r_mode <= rsc_pkg::MODE_UNUSED;
                r_refs <= '0;
                r_seq  <= '0;
            end else if (i_cmd.release_dec) begin
                r_refs <= r_refs - REF_BITS'(1);
                if (i_cmd.go_warm) begin
                    r_mode <= rsc_pkg::MODE_WARM;
                    r_seq  <= i_cmd.stamp;
                end
            end
        end
    end

    assign o_mode  = r_mode;
    assign o_refs  = r_refs;
    assign o_seq   = r_seq;
    assign o_match = (r_mode != rsc_pkg::MODE_UNUSED) && (r_key == i_key);
endmodule

/* design/refcounted_slot_cache_lru_evict_top.sv */
// Slot cache with reference counts and eviction of the oldest idle slot.
// Acquire examines one slot per cycle in the scan state, then commits in the DO state
// and shows its result in the OUT state; release, flush and unknown codes skip the scan.
// busy stays high through the result strobe; the result is shown for one cycle and
// cannot be stalled. Depends on rsc_pkg, rsc_cell and the defines header.
`include "refcounted_slot_cache_lru_evict_top_defines.svh"
module refcounted_slot_cache_lru_evict_top #(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 64,
    parameter int REF_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  rsc_pkg::t_in_item  i_item,
    output logic               o_valid,
    output rsc_pkg::t_out_item o_item
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DO   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]          r_state;
    logic [CW-1:0]       r_cnt;
    rsc_pkg::t_in_item   r_req;
    logic [KEY_BITS-1:0] w_key;
    logic                r_hit_f, r_free_f, r_vic_f;
    logic [IW-1:0]       r_hit_i, r_vic_i;
    logic [31:0]         r_vic_seq, r_clock;
    rsc_pkg::t_out_item  r_out;
    logic                r_ovalid;

    logic [1:0]          w_mode  [SLOTS];
    logic [REF_BITS-1:0] w_refs  [SLOTS];
    logic [31:0]         w_seq   [SLOTS];
    logic                w_match [SLOTS];
    logic [SLOTS-1:0]    w_sel;
    rsc_pkg::t_cell_cmd  w_cmd;

    logic [IW-1:0] w_ci, w_ri, w_ti;
    logic          w_rel_ok;

    assign w_key = r_req.key[KEY_BITS-1:0];
    assign w_ci  = r_cnt[IW-1:0];
    assign w_ri  = IW'(r_req.slot_index);
    assign w_rel_ok = ({28'd0, r_req.slot_index} < 32'(SLOTS))
        && w_mode[w_ri] != rsc_pkg::MODE_UNUSED && w_refs[w_ri] != '0;
    assign w_ti = r_hit_f ? r_hit_i : r_vic_i;

    always_comb begin
        w_cmd = '0;
        w_cmd.stamp = r_clock + 32'd1;
        w_sel = '0;
        if (r_state == S_DO) begin
            case (r_req.func)
                rsc_pkg::FUNC_ACQUIRE: begin
                    w_sel[w_ti] = r_hit_f || r_vic_f;
                    if (r_hit_f) begin
                        w_cmd.warm_hit = (w_mode[r_hit_i] == rsc_pkg::MODE_WARM);
                        w_cmd.bump     = !w_cmd.warm_hit;
                    end else begin
                        w_cmd.load  = r_req.load_ok;
                        w_cmd.clear = !r_req.load_ok;
                    end
                end
                rsc_pkg::FUNC_RELEASE: begin
                    w_sel[w_ri] = w_rel_ok;
                    w_cmd.release_dec = 1'b1;
                    w_cmd.go_warm = (w_refs[w_ri] == REF_BITS'(1));
                end
                rsc_pkg::FUNC_FLUSH: w_cmd.flush = 1'b1;
                default: w_sel = '0;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            rsc_cell #(.KEY_BITS(KEY_BITS), .REF_BITS(REF_BITS)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sel(w_sel[g]), .i_cmd(w_cmd),
                .i_key(w_key), .o_mode(w_mode[g]), .o_refs(w_refs[g]),
                .o_seq(w_seq[g]), .o_match(w_match[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_clock  <= '0;
        end else begin
            r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req    <= i_item;
                        r_cnt    <= '0;
                        r_hit_f  <= 1'b0;
                        r_free_f <= 1'b0;
                        r_vic_f  <= 1'b0;
                        r_state  <= (i_item.func == rsc_pkg::FUNC_ACQUIRE) ? S_SCAN : S_DO;
                    end
                end
                S_SCAN: begin
                    if (!r_hit_f && w_match[w_ci]) begin
                        r_hit_f <= 1'b1;
                        r_hit_i <= w_ci;
                    end
                    if (!r_free_f) begin
                        if (w_mode[w_ci] == rsc_pkg::MODE_UNUSED) begin
                            r_free_f <= 1'b1;
                            r_vic_f  <= 1'b1;
                            r_vic_i  <= w_ci;
                        end else if (w_mode[w_ci] == rsc_pkg::MODE_WARM
                                     && (!r_vic_f || w_seq[w_ci] < r_vic_seq)) begin
                            r_vic_f   <= 1'b1;
                            r_vic_i   <= w_ci;
                            r_vic_seq <= w_seq[w_ci];
                        end
                    end
                    if (r_cnt == CW'(SLOTS - 1)) begin
                        r_state <= S_DO;
                    end
                    r_cnt <= r_cnt + CW'(1);
                end
                S_DO: begin
                    r_out <= '0;
                    case (r_req.func)
                        rsc_pkg::FUNC_ACQUIRE: begin
                            if (r_hit_f) begin
                                r_out.handle_slot <= 4'(r_hit_i);
                                r_out.hit <= 1'b1;
                            end else if (!r_vic_f) begin
                                r_out.status <= rsc_pkg::ST_FULL;
                            end else if (!r_req.load_ok) begin
                                r_out.status <= rsc_pkg::ST_LOADFAIL;
                            end else begin
                                r_out.handle_slot <= 4'(r_vic_i);
                            end
                        end
                        rsc_pkg::FUNC_RELEASE: begin
                            if (!w_rel_ok) begin
                                r_out.status <= rsc_pkg::ST_INVALID;
                            end else if (w_cmd.go_warm) begin
                                r_clock <= w_cmd.stamp;
                            end
                        end
                        rsc_pkg::FUNC_FLUSH: r_clock <= '0;
                        default: r_out.status <= rsc_pkg::ST_INVALID;
                    endcase
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    `RSC_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `RSC_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `RSC_ASSERT_IMP(a_one_sel, i_clk, i_rst_n, 1'b1, $onehot0(w_sel))
    `RSC_ASSERT_IMP(a_fail_clean, i_clk, i_rst_n,
        o_valid && o_item.status != rsc_pkg::ST_OK, o_item.hit == 1'b0)
endmodule

/* verif/testbench.sv */
// Self-checking testbench for the reference-counted slot cache with LRU eviction.
// Drives acquire, release, flush and unknown-code items, predicts each result and compares it.
// Depends on rsc_pkg and refcounted_slot_cache_lru_evict_top.
module testbench;
    localparam int NSLOT = 16;
    localparam int IN_BITS = $bits(rsc_pkg::t_in_item);
    localparam logic [1:0] FUNC_BAD = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    rsc_pkg::t_in_item  i_item = '0;
    logic               o_valid;
    rsc_pkg::t_out_item o_item;

    logic [1:0]  mdl_mode [NSLOT];
    logic [63:0] mdl_key [NSLOT];
    logic [15:0] mdl_refs [NSLOT];
    logic [31:0] mdl_stamp [NSLOT];
    logic [31:0] mdl_clock;
    rsc_pkg::t_out_item pending_results [$];
    int          fail_count = 0;
    bit          gaps_on = 1'b1;
    logic [63:0] key_pool [8];

    refcounted_slot_cache_lru_evict_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_item(o_item)
    );

    always #4 i_clk = ~i_clk;

    function automatic void cache_clear_all();
        for (int s = 0; s < NSLOT; s++) begin
            mdl_mode[s] = rsc_pkg::MODE_UNUSED;
            mdl_key[s] = '0;
            mdl_refs[s] = '0;
            mdl_stamp[s] = '0;
        end
        mdl_clock = '0;
    endfunction

    function automatic rsc_pkg::t_out_item cache_predict(rsc_pkg::t_in_item it);
        rsc_pkg::t_out_item r;
        int victim;
        r = '0;
        victim = -1;
        case (it.func)
            rsc_pkg::FUNC_ACQUIRE: begin
                for (int s = 0; s < NSLOT; s++) begin
                    if (victim < 0 && mdl_mode[s] != rsc_pkg::MODE_UNUSED
                            && mdl_key[s] == it.key) begin
                        victim = s;
                    end
                end
                if (victim >= 0) begin
                    if (mdl_mode[victim] == rsc_pkg::MODE_WARM) begin
                        mdl_mode[victim] = rsc_pkg::MODE_ACTIVE;
                        mdl_refs[victim] = 16'd1;
                        mdl_stamp[victim] = '0;
                    end else if (mdl_refs[victim] != 16'hffff) begin
                        mdl_refs[victim]++;
                    end
                    r.status = rsc_pkg::ST_OK;
                    r.handle_slot = victim[3:0];
                    r.hit = 1'b1;
                    return r;
                end
                for (int s = 0; s < NSLOT; s++) begin
                    if (mdl_mode[s] == rsc_pkg::MODE_UNUSED) begin
                        victim = s;
                        break;
                    end
                    if (mdl_mode[s] == rsc_pkg::MODE_WARM
                            && (victim < 0 || mdl_stamp[s] < mdl_stamp[victim])) begin
                        victim = s;
                    end
                end
                if (victim < 0) begin
                    r.status = rsc_pkg::ST_FULL;
                end else begin
                    mdl_mode[victim] = rsc_pkg::MODE_UNUSED;
                    mdl_key[victim] = '0;
                    mdl_refs[victim] = '0;
                    mdl_stamp[victim] = '0;
                    if (!it.load_ok) begin
                        r.status = rsc_pkg::ST_LOADFAIL;
                    end else begin
                        mdl_key[victim] = it.key;
                        mdl_refs[victim] = 16'd1;
                        mdl_mode[victim] = rsc_pkg::MODE_ACTIVE;
                        r.status = rsc_pkg::ST_OK;
                        r.handle_slot = victim[3:0];
                    end
                end
            end
            rsc_pkg::FUNC_RELEASE: begin
                if (mdl_mode[it.slot_index] == rsc_pkg::MODE_UNUSED
                        || mdl_refs[it.slot_index] == 0) begin
                    r.status = rsc_pkg::ST_INVALID;
                end else begin
                    mdl_refs[it.slot_index]--;
                    if (mdl_refs[it.slot_index] == 0) begin
                        mdl_mode[it.slot_index] = rsc_pkg::MODE_WARM;
                        mdl_clock++;
                        mdl_stamp[it.slot_index] = mdl_clock;
                    end
                    r.status = rsc_pkg::ST_OK;
                end
            end
            rsc_pkg::FUNC_FLUSH: begin
                cache_clear_all();
                r.status = rsc_pkg::ST_OK;
            end
            default: begin
                r.status = rsc_pkg::ST_INVALID;
            end
        endcase
        return r;
    endfunction

    task automatic send_item(logic [1:0] func, logic [63:0] key, logic [3:0] idx, logic ok);
        rsc_pkg::t_in_item it;
        it.func = func;
        it.key = key;
        it.slot_index = idx;
        it.load_ok = ok;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(cache_predict(it));
        start <= 1'b0;
        i_item <= IN_BITS'({$urandom(), $urandom(), $urandom()});
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        rsc_pkg::t_out_item want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with none expected: %h", o_item);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_item.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_item.status);
                    fail_count++;
                end
                if (o_item.handle_slot !== want.handle_slot) begin
                    $error("handle_slot expected %0d actual %0d",
                           want.handle_slot, o_item.handle_slot);
                    fail_count++;
                end
                if (o_item.hit !== want.hit) begin
                    $error("hit expected %0d actual %0d", want.hit, o_item.hit);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        send_item(rsc_pkg::FUNC_RELEASE, '0, 4'd0, 1'b1);
        send_item(FUNC_BAD, '1, 4'd15, 1'b1);
        send_item(rsc_pkg::FUNC_ACQUIRE, 64'd0, 4'd0, 1'b1);
        send_item(rsc_pkg::FUNC_ACQUIRE, '1, 4'd15, 1'b1);
        send_item(rsc_pkg::FUNC_ACQUIRE, '1, 4'd0, 1'b0);
        send_item(rsc_pkg::FUNC_ACQUIRE, 64'h5555_aaaa_5555_aaaa, 4'd0, 1'b0);
        send_item(rsc_pkg::FUNC_RELEASE, '0, 4'd1, 1'b0);
        send_item(rsc_pkg::FUNC_RELEASE, '0, 4'd1, 1'b0);
        send_item(rsc_pkg::FUNC_ACQUIRE, '1, 4'd0, 1'b1);
        send_item(rsc_pkg::FUNC_RELEASE, '0, 4'd0, 1'b1);
        send_item(rsc_pkg::FUNC_FLUSH, '1, 4'd15, 1'b0);
        send_item(rsc_pkg::FUNC_RELEASE, '0, 4'd0, 1'b1);
    endtask

    task automatic test_full_and_evict();
        for (int s = 0; s < NSLOT; s++) begin
            send_item(rsc_pkg::FUNC_ACQUIRE, 64'h100 + 64'(s), 4'(s), 1'b1);
        end
        send_item(rsc_pkg::FUNC_ACQUIRE, 64'h999, 4'd0, 1'b1);
        send_item(rsc_pkg::FUNC_RELEASE, '0, 4'd9, 1'b1);
        send_item(rsc_pkg::FUNC_RELEASE, '0, 4'd3, 1'b1);
        send_item(rsc_pkg::FUNC_RELEASE, '0, 4'd3, 1'b1);
        send_item(rsc_pkg::FUNC_ACQUIRE, 64'h999, 4'd0, 1'b1);
        send_item(rsc_pkg::FUNC_ACQUIRE, 64'h998, 4'd0, 1'b0);
        send_item(rsc_pkg::FUNC_ACQUIRE, 64'h998, 4'd0, 1'b1);
        wait_drained();
        send_item(rsc_pkg::FUNC_FLUSH, '0, 4'd0, 1'b1);
    endtask

    task automatic test_repeated_hits();
        for (int n = 0; n < 6; n++) send_item(rsc_pkg::FUNC_ACQUIRE, 64'h77, 4'd0, 1'b1);
        for (int n = 0; n < 7; n++) send_item(rsc_pkg::FUNC_RELEASE, '0, 4'd0, 1'b1);
        send_item(rsc_pkg::FUNC_ACQUIRE, 64'h77, 4'd0, 1'b1);
        send_item(rsc_pkg::FUNC_FLUSH, '0, 4'd0, 1'b1);
    endtask

    task automatic test_random(int count);
        logic [63:0] k;
        for (int n = 0; n < count; n++) begin
            if (n > count * 4 / 5) gaps_on = 1'b0;
            k = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()}
                                            : key_pool[$urandom_range(0, 7)];
            case ($urandom_range(0, 19))
                0: send_item(rsc_pkg::FUNC_FLUSH, k, 4'($urandom()), 1'($urandom()));
                1: send_item(FUNC_BAD, k, 4'($urandom()), 1'($urandom()));
                2, 3, 4, 5, 6, 7, 8: begin
                    send_item(rsc_pkg::FUNC_RELEASE, k, 4'($urandom()), 1'($urandom()));
                end
                default: send_item(rsc_pkg::FUNC_ACQUIRE, k, 4'($urandom()),
                                   1'($urandom_range(0, 7) != 0));
            endcase
        end
    endtask

    initial begin
        for (int p = 0; p < 8; p++) key_pool[p] = {$urandom(), $urandom()};
        key_pool[0] = '0;
        cache_clear_all();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_and_evict();
        test_repeated_hits();
        test_random(400);
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

/* files.f */
+incdir+design
design/rsc_pkg.sv
design/rsc_cell.sv
design/refcounted_slot_cache_lru_evict_top.sv
verif/testbench.sv
